FILE: src/ocsse_pkg.sv
package ocsse_pkg;

    localparam int FRAC_BITS        = 32;
    localparam int SPO_LOG2         = 3;
    localparam int MIN_W_LOG2       = 24;
    localparam int SEG_COUNT        = 256;
    localparam int DOMAIN_MIN_SHIFT = MIN_W_LOG2 + SPO_LOG2;

    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] REGION_SUBNORMAL = 2'd0;
    localparam logic [1:0] REGION_OCTAVE    = 2'd1;
    localparam logic [1:0] REGION_RUNOUT    = 2'd2;
    localparam logic [1:0] REGION_LINEAR    = 2'd3;

    localparam logic [2:0] CFG_VELOCITY_SCALE  = 3'd0;
    localparam logic [2:0] CFG_GEOMETRIC_LIMIT = 3'd1;
    localparam logic [2:0] CFG_RUNOUT_LIMIT    = 3'd2;
    localparam logic [2:0] CFG_RUNOUT_WIDTH    = 3'd3;
    localparam logic [2:0] CFG_RUNOUT_A        = 3'd4;
    localparam logic [2:0] CFG_RUNOUT_B        = 3'd5;
    localparam logic [2:0] CFG_RUNOUT_C        = 3'd6;
    localparam logic [2:0] CFG_RUNOUT_D        = 3'd7;

    typedef struct packed {
        logic               operation;
        logic signed [63:0] velocity;
        logic [7:0]         entry_index;
        logic [1:0]         coeff_select;
        logic signed [63:0] coeff_value;
    } in_word_t;

    typedef struct packed {
        logic signed [63:0] curve_value;
        logic [1:0]         region;
        logic               index_saturated;
    } out_word_t;

endpackage

FILE: src/octave_segmented_cubic_spline_eval.sv
// Throughput: one word per cycle; the whole pipeline advances in lockstep and
// holds only while a finished word waits on out_stall.
// Each 64-bit product is split into 32-bit partial products over two stages.
// Reset clears valid bits and presets config registers; table is undefined until written.
module octave_segmented_cubic_spline_eval
    import ocsse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word,
    input  logic      cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int SEGW = $clog2(SEG_COUNT);
    localparam int IDXW = 6 + SPO_LOG2 + 1;
    localparam int PW   = 64 + FRAC_BITS;

    typedef struct packed {
        logic        op;
        logic [62:0] v;
        logic [7:0]  entry;
        logic [1:0]  sel;
        logic [63:0] coeff;
        logic [62:0] x;
        logic        ge_geo;
        logic        ge_run;
        logic [63:0] dx_geo;
        logic [63:0] dx_run;
        logic [7:0]  grp_nz;
        logic [7:0][2:0] grp_pos;
        logic [5:0]  lg;
        logic [1:0]  region;
        logic [5:0]  w;
    } front_t;

    typedef struct packed {
        logic [63:0]      acc;
        logic [63:0]      t;
        logic [2:0][63:0] k;
        logic [1:0]       region;
        logic             sat;
    } hstage_t;

    typedef struct packed {
        hstage_t     h;
        logic [63:0] ll;
        logic [63:0] lh;
        logic [64:0] hl;
        logic [64:0] hh;
    } mstage_t;

    typedef struct packed {
        hstage_t       h;
        logic [PW-1:0] p;
    } pstage_t;

    function automatic logic [63:0] pos_to_t(input logic [63:0] x, input logic [5:0] w);
        logic [63:0] rem;
        rem = x & ((64'd1 << w) - 64'd1);
        if (w < 6'(FRAC_BITS))
            return rem << (6'(FRAC_BITS) - w);
        else
            return rem >> (w - 6'(FRAC_BITS));
    endfunction

    logic [62:0] scale_reg, geo_reg, run_reg;
    logic [5:0]  rw_reg;
    logic [3:0][63:0] rk_reg;
    logic signed [127:0] dy_reg;
    logic [63:0] slope_reg, y0_reg;
    logic signed [127:0] dy_next;
    logic [63:0] slope_next;

    logic adv;

    in_word_t s0_reg;
    logic     v0_reg;
    front_t   fa_reg, fb_reg, fc_reg, fd_reg, fe_reg;
    logic     va_reg, vb_reg, vc_reg, vd_reg, ve_reg;
    logic [3:0][63:0] pa_reg;
    logic [127:0]     pb_reg;
    hstage_t  f_reg;
    logic     vf_reg;
    logic [3:0][63:0] mem [SEG_COUNT];
    logic [3:0][63:0] rdata_reg;

    mstage_t m1_reg [3];
    pstage_t p_reg  [3];
    hstage_t h_reg  [3];
    logic [2:0] vm1_reg, vp_reg, vh_reg;

    front_t   fa_next, fc_next, fd_next, fe_next;
    logic [3:0][63:0] pa_next;
    logic [127:0]     q_next;
    hstage_t  f_next, g_in;
    logic [IDXW-1:0]  idx;
    logic [SEGW-1:0]  raddr;
    logic             mem_we;
    mstage_t m1_next [3];
    pstage_t p_next  [3];
    hstage_t h_next  [3];

    assign adv      = !(vh_reg[2] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= 63'd4294967296;
            geo_reg   <= '0;
            run_reg   <= '0;
            rw_reg    <= 6'd32;
            rk_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VELOCITY_SCALE:  scale_reg <= cfg_data[62:0];
                CFG_GEOMETRIC_LIMIT: geo_reg   <= cfg_data[62:0];
                CFG_RUNOUT_LIMIT:    run_reg   <= cfg_data[62:0];
                CFG_RUNOUT_WIDTH:    rw_reg    <= cfg_data[5:0];
                CFG_RUNOUT_A:        rk_reg[0] <= cfg_data;
                CFG_RUNOUT_B:        rk_reg[1] <= cfg_data;
                CFG_RUNOUT_C:        rk_reg[2] <= cfg_data;
                CFG_RUNOUT_D:        rk_reg[3] <= cfg_data;
                default:             ;
            endcase
        end
    end

    // The tangent at the end of the runout segment depends only on registers.
    always_comb
    begin
        dy_next = $signed({{64{rk_reg[0][63]}}, rk_reg[0]}) * 128'sd3
                + $signed({{64{rk_reg[1][63]}}, rk_reg[1]}) * 128'sd2
                + $signed({{64{rk_reg[2][63]}}, rk_reg[2]});
        if (rw_reg <= 6'(FRAC_BITS))
            slope_next = 64'(dy_reg <<< (6'(FRAC_BITS) - rw_reg));
        else
            slope_next = 64'(dy_reg >>> (rw_reg - 6'(FRAC_BITS)));
    end

    always_ff @(posedge clk)
    begin
        dy_reg    <= dy_next;
        slope_reg <= slope_next;
        y0_reg    <= rk_reg[0] + rk_reg[1] + rk_reg[2] + rk_reg[3];
    end

    always_comb
    begin
        fa_next       = '0;
        fa_next.op    = s0_reg.operation;
        fa_next.v     = s0_reg.velocity[63] ? 63'd0 : s0_reg.velocity[62:0];
        fa_next.entry = s0_reg.entry_index;
        fa_next.sel   = s0_reg.coeff_select;
        fa_next.coeff = s0_reg.coeff_value;
        pa_next[0] = {32'd0, fa_next.v[31:0]} * {32'd0, scale_reg[31:0]};
        pa_next[1] = {32'd0, fa_next.v[31:0]} * {33'd0, scale_reg[62:32]};
        pa_next[2] = {33'd0, fa_next.v[62:32]} * {32'd0, scale_reg[31:0]};
        pa_next[3] = {33'd0, fa_next.v[62:32]} * {33'd0, scale_reg[62:32]};
    end

    always_comb
    begin
        q_next  = pb_reg + (128'd1 << (FRAC_BITS - 1));
        fc_next = fb_reg;
        if (|q_next[127:FRAC_BITS + 63])
            fc_next.x = '1;
        else
            fc_next.x = q_next[FRAC_BITS +: 63];
    end

    always_comb
    begin
        logic [63:0] xx;
        fd_next        = fc_reg;
        xx             = {1'b0, fc_reg.x};
        fd_next.ge_geo = fc_reg.x >= geo_reg;
        fd_next.ge_run = fc_reg.x >= run_reg;
        fd_next.dx_geo = {1'b0, fc_reg.x - geo_reg};
        fd_next.dx_run = {1'b0, fc_reg.x - run_reg};
        for (int g = 0; g < 8; g++)
        begin
            fd_next.grp_nz[g]  = |xx[8 * g +: 8];
            fd_next.grp_pos[g] = 3'd0;
            for (int b = 0; b < 8; b++)
            begin
                if (xx[8 * g + b])
                    fd_next.grp_pos[g] = 3'(b);
            end
        end
    end

    always_comb
    begin
        fe_next    = fd_reg;
        fe_next.lg = 6'd0;
        for (int g = 0; g < 8; g++)
        begin
            if (fd_reg.grp_nz[g])
                fe_next.lg = {3'(g), fd_reg.grp_pos[g]};
        end
        if (fe_next.lg < 6'(DOMAIN_MIN_SHIFT))
        begin
            fe_next.w      = 6'(MIN_W_LOG2);
            fe_next.region = REGION_SUBNORMAL;
        end
        else
        begin
            fe_next.w      = 6'(MIN_W_LOG2) + (fe_next.lg - 6'(DOMAIN_MIN_SHIFT));
            fe_next.region = REGION_OCTAVE;
        end
        if (fd_reg.ge_geo)
            fe_next.region = fd_reg.ge_run ? REGION_LINEAR : REGION_RUNOUT;
    end

    always_comb
    begin
        logic [IDXW-1:0] base;
        f_next        = '0;
        f_next.region = fe_reg.region;
        if (fe_reg.region == REGION_OCTAVE)
            base = IDXW'(fe_reg.lg - 6'(DOMAIN_MIN_SHIFT)) << SPO_LOG2;
        else
            base = '0;
        idx = base + IDXW'({1'b0, fe_reg.x} >> fe_reg.w);
        f_next.sat = (fe_reg.region == REGION_SUBNORMAL || fe_reg.region == REGION_OCTAVE)
                     && (32'(idx) >= SEG_COUNT);
        raddr = f_next.sat ? SEGW'(SEG_COUNT - 1) : SEGW'(idx);
        case (fe_reg.region)
            REGION_RUNOUT: f_next.t = pos_to_t(fe_reg.dx_geo, rw_reg);
            REGION_LINEAR: f_next.t = fe_reg.dx_run;
            default:       f_next.t = pos_to_t({1'b0, fe_reg.x}, fe_reg.w);
        endcase
        mem_we = adv && ve_reg && (fe_reg.op == OP_WRITE) && (32'(fe_reg.entry) < SEG_COUNT);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[SEGW'(fe_reg.entry)][fe_reg.sel] <= fe_reg.coeff;
        if (adv)
            rdata_reg <= mem[raddr];
    end

    // The linear extension runs through the same Horner chain as 0, 0, slope, y0.
    always_comb
    begin
        g_in = f_reg;
        case (f_reg.region)
            REGION_RUNOUT:
            begin
                g_in.acc = rk_reg[0];
                g_in.k   = {rk_reg[3], rk_reg[2], rk_reg[1]};
            end
            REGION_LINEAR:
            begin
                g_in.acc = '0;
                g_in.k   = {y0_reg, slope_reg, 64'd0};
            end
            default:
            begin
                g_in.acc = rdata_reg[0];
                g_in.k   = {rdata_reg[3], rdata_reg[2], rdata_reg[1]};
            end
        endcase
    end

    always_comb
    begin
        hstage_t       src;
        logic [PW-1:0] rnd;
        for (int j = 0; j < 3; j++)
        begin
            src = (j == 0) ? g_in : h_reg[(j == 0) ? 0 : j - 1];
            m1_next[j].h  = src;
            m1_next[j].ll = {32'd0, src.acc[31:0]} * {32'd0, src.t[31:0]};
            m1_next[j].lh = {32'd0, src.acc[31:0]} * {32'd0, src.t[63:32]};
            m1_next[j].hl = 65'($signed(src.acc[63:32]) * $signed({1'b0, src.t[31:0]}));
            m1_next[j].hh = 65'($signed(src.acc[63:32]) * $signed({1'b0, src.t[63:32]}));
            p_next[j].h = m1_reg[j].h;
            p_next[j].p = PW'(m1_reg[j].ll)
                        + PW'({m1_reg[j].lh, 32'd0})
                        + PW'({{31{m1_reg[j].hl[64]}}, m1_reg[j].hl, 32'd0})
                        + PW'({{31{m1_reg[j].hh[64]}}, m1_reg[j].hh, 64'd0});
            rnd            = p_reg[j].p + (PW'(1) << (FRAC_BITS - 1));
            h_next[j]      = p_reg[j].h;
            h_next[j].acc  = rnd[FRAC_BITS +: 64] + p_reg[j].h.k[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            va_reg  <= 1'b0;
            vb_reg  <= 1'b0;
            vc_reg  <= 1'b0;
            vd_reg  <= 1'b0;
            ve_reg  <= 1'b0;
            vf_reg  <= 1'b0;
            vm1_reg <= '0;
            vp_reg  <= '0;
            vh_reg  <= '0;
        end
        else if (adv)
        begin
            v0_reg  <= in_valid;
            va_reg  <= v0_reg;
            vb_reg  <= va_reg;
            vc_reg  <= vb_reg;
            vd_reg  <= vc_reg;
            ve_reg  <= vd_reg;
            vf_reg  <= ve_reg && (fe_reg.op == OP_EVAL);
            vm1_reg <= {vh_reg[1:0], vf_reg};
            vp_reg  <= vm1_reg;
            vh_reg  <= vp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_reg   <= in_word;
            fa_reg   <= fa_next;
            pa_reg   <= pa_next;
            fb_reg   <= fa_reg;
            pb_reg   <= 128'(pa_reg[0]) + 128'({pa_reg[1], 32'd0})
                      + 128'({pa_reg[2], 32'd0}) + {pa_reg[3], 64'd0};
            fc_reg   <= fc_next;
            fd_reg   <= fd_next;
            fe_reg   <= fe_next;
            f_reg    <= f_next;
            for (int j = 0; j < 3; j++)
            begin
                m1_reg[j] <= m1_next[j];
                p_reg[j]  <= p_next[j];
                h_reg[j]  <= h_next[j];
            end
        end
    end

    assign out_valid                = vh_reg[2];
    assign out_word.curve_value     = h_reg[2].acc;
    assign out_word.region          = h_reg[2].region;
    assign out_word.index_saturated = h_reg[2].sat;

endmodule

FILE: src/ocsse_checker.sv
module ocsse_checker
    import ocsse_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_word_t out_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("Stalled output word changed.");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("Input stalled without a blocked output word.");

    a_no_stall_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("Input stalled while the output is empty.");

    a_sat_region: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_word.region == REGION_RUNOUT || out_word.region == REGION_LINEAR)
        |-> !out_word.index_saturated)
        else $error("Saturation flagged outside the table regions.");

endmodule

bind octave_segmented_cubic_spline_eval ocsse_checker u_ocsse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
);
